>>> rtl/alle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_pkg
// Shared constants and types for the array linked list engine: store
// geometry, operation and status codes, sequencer states, allocator commands.
// ----------------------------------------------------------------------------
package alle_pkg;

    localparam int DEPTH  = 128;
    localparam int NODE_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 7;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WALK   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_FINISH = 6'b001000,
        S_RELINK = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    typedef struct packed {
        logic fetch;   // read the top of the free stack
        logic take;    // consume the offered free node
        logic push;    // return a node to the free stack
    } free_cmd_t;

endpackage

>>> rtl/alle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/alle_free.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_free
// Free node allocator: a stack of released nodes backed by a RAM, plus a
// high-water mark of nodes never handed out since reset.
// ----------------------------------------------------------------------------
module alle_free (
    input  logic                        clk,
    input  logic                        rst_n,
    input  alle_pkg::free_cmd_t         cmd,
    input  logic [alle_pkg::NODE_W-1:0] push_node,
    output logic [alle_pkg::NODE_W-1:0] node
);

    logic [alle_pkg::NODE_W-1:0] sp_reg;
    logic [alle_pkg::NODE_W-1:0] sp_next;
    logic [alle_pkg::NODE_W:0]   fresh_reg;
    logic [alle_pkg::NODE_W:0]   fresh_next;
    logic [alle_pkg::NODE_W-1:0] stack_rdata;
    logic                        stack_nonempty;

    assign stack_nonempty = (sp_reg != '0);

    alle_ram #(
        .WIDTH (alle_pkg::NODE_W),
        .DEPTH (alle_pkg::DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (sp_reg),
        .wdata (push_node),
        .re    (cmd.fetch),
        .raddr (sp_reg - 1'b1),
        .rdata (stack_rdata)
    );

    // Prefer recycled nodes; fall back to the untouched region
    assign node = stack_nonempty ? stack_rdata : fresh_reg[alle_pkg::NODE_W-1:0];

    always_comb
    begin
        sp_next    = sp_reg;
        fresh_next = fresh_reg;
        if (cmd.take)
        begin
            if (stack_nonempty)
            begin
                sp_next = sp_reg - 1'b1;
            end
            else
            begin
                fresh_next = fresh_reg + 1'b1;
            end
        end
        else if (cmd.push)
        begin
            sp_next = sp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            fresh_reg <= (alle_pkg::NODE_W + 1)'(1);
        end
        else
        begin
            sp_reg    <= sp_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

>>> rtl/array_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_unit
// Ordered list of signed values kept as linked nodes in a node store, with
// insert, delete and read at a one-based logical position.
// ----------------------------------------------------------------------------
// One request is handled at a time. Errors and the unused function code go
// straight to the response; the other requests walk along the list, which
// follows one link per cycle through the link RAM read port, so a request
// near the tail takes longest. The header link lives in a register, so the
// block is ready right after reset with no clearing pass. A finished result
// sits in the output register while the next request is taken.
module array_linked_list_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [alle_pkg::FUNC_W-1:0]        func,
    input  logic [alle_pkg::POS_W-1:0]         pos,
    input  logic signed [alle_pkg::DATA_W-1:0] data,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [alle_pkg::STAT_W-1:0]        status,
    output logic signed [alle_pkg::DATA_W-1:0] value,
    output logic [alle_pkg::LEN_W-1:0]         length
);

    alle_pkg::state_t state_reg;
    alle_pkg::state_t state_next;

    logic [alle_pkg::FUNC_W-1:0] func_reg;
    logic [alle_pkg::DATA_W-1:0] data_reg;
    logic [alle_pkg::POS_W-1:0]  remain_reg;
    logic [alle_pkg::NODE_W-1:0] cur_reg;
    logic                        from_head_reg;
    logic [alle_pkg::NODE_W-1:0] prev_reg;
    logic [alle_pkg::NODE_W-1:0] nxt_reg;
    logic [alle_pkg::NODE_W-1:0] fr_reg;
    logic [alle_pkg::NODE_W-1:0] head_reg;
    logic [alle_pkg::LEN_W-1:0]  count_reg;
    logic [alle_pkg::STAT_W-1:0] res_status_reg;
    logic [alle_pkg::DATA_W-1:0] res_value_reg;

    logic                        rsp_valid_reg;
    logic [alle_pkg::STAT_W-1:0] status_reg;
    logic [alle_pkg::DATA_W-1:0] value_reg;
    logic [alle_pkg::LEN_W-1:0]  length_reg;

    logic                        accept;
    logic                        is_full;
    logic                        ins_bad;
    logic                        acc_bad;
    logic [alle_pkg::LEN_W:0]    pos_x;
    logic [alle_pkg::LEN_W:0]    cnt_x;
    logic [alle_pkg::NODE_W-1:0] link_now;
    logic                        walk_done;
    logic                        resp_load;

    logic                        link_we;
    logic [alle_pkg::NODE_W-1:0] link_waddr;
    logic [alle_pkg::NODE_W-1:0] link_wdata;
    logic                        link_re;
    logic [alle_pkg::NODE_W-1:0] link_raddr;
    logic [alle_pkg::NODE_W-1:0] link_rdata;
    logic                        val_we;
    logic                        val_re;
    logic [alle_pkg::DATA_W-1:0] val_rdata;

    alle_pkg::free_cmd_t         free_cmd;
    logic [alle_pkg::NODE_W-1:0] free_node;

    assign req_ready = (state_reg == alle_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;

    assign pos_x   = {1'b0, pos};
    assign cnt_x   = {1'b0, count_reg};
    assign is_full = (count_reg == alle_pkg::LEN_W'(alle_pkg::DEPTH - 1));
    assign ins_bad = (pos == '0) || (pos_x > cnt_x + 1'b1);
    assign acc_bad = (pos == '0) || (pos > count_reg);

    // Link of the node the walk stands on: header register or last RAM read
    assign link_now  = from_head_reg ? head_reg : link_rdata;
    assign walk_done = (remain_reg == '0);
    assign resp_load = (state_reg == alle_pkg::S_RESP) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        link_re    = 1'b0;
        link_raddr = nxt_reg;
        val_re     = 1'b0;
        free_cmd   = '0;
        link_we    = 1'b0;
        link_waddr = prev_reg;
        link_wdata = fr_reg;
        val_we     = 1'b0;
        case (state_reg)
            alle_pkg::S_WALK:
            begin
                link_raddr = link_now;
                link_re    = !walk_done;
            end
            alle_pkg::S_FETCH:
            begin
                link_re        = (func_reg == alle_pkg::FUNC_DELETE);
                val_re         = 1'b1;
                free_cmd.fetch = (func_reg == alle_pkg::FUNC_INSERT);
            end
            alle_pkg::S_FINISH:
            begin
                if (func_reg == alle_pkg::FUNC_INSERT)
                begin
                    val_we        = 1'b1;
                    link_we       = 1'b1;
                    link_waddr    = free_node;
                    link_wdata    = nxt_reg;
                    free_cmd.take = 1'b1;
                end
                else if (func_reg == alle_pkg::FUNC_DELETE)
                begin
                    // Bypass the victim; the header link is a register
                    link_we       = (prev_reg != '0);
                    link_wdata    = link_rdata;
                    free_cmd.push = 1'b1;
                end
            end
            alle_pkg::S_RELINK:
            begin
                link_we = (prev_reg != '0);
            end
            default:
            begin
                link_re = 1'b0;
            end
        endcase
    end

    alle_ram #(
        .WIDTH (alle_pkg::NODE_W),
        .DEPTH (alle_pkg::DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    alle_ram #(
        .WIDTH (alle_pkg::DATA_W),
        .DEPTH (alle_pkg::DEPTH)
    ) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (free_node),
        .wdata (data_reg),
        .re    (val_re),
        .raddr (nxt_reg),
        .rdata (val_rdata)
    );

    alle_free u_free (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (free_cmd),
        .push_node (nxt_reg),
        .node      (free_node)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alle_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (func == alle_pkg::FUNC_INSERT)
                    begin
                        state_next = (is_full || ins_bad) ? alle_pkg::S_RESP : alle_pkg::S_WALK;
                    end
                    else if (func == alle_pkg::FUNC_DELETE || func == alle_pkg::FUNC_READ)
                    begin
                        state_next = acc_bad ? alle_pkg::S_RESP : alle_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = alle_pkg::S_RESP;
                    end
                end
            end
            alle_pkg::S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = alle_pkg::S_FETCH;
                end
            end
            alle_pkg::S_FETCH:
            begin
                state_next = alle_pkg::S_FINISH;
            end
            alle_pkg::S_FINISH:
            begin
                state_next = (func_reg == alle_pkg::FUNC_INSERT) ?
                             alle_pkg::S_RELINK : alle_pkg::S_RESP;
            end
            alle_pkg::S_RELINK:
            begin
                state_next = alle_pkg::S_RESP;
            end
            alle_pkg::S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = alle_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = alle_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alle_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == alle_pkg::S_FINISH && func_reg == alle_pkg::FUNC_DELETE)
            begin
                count_reg <= count_reg - 1'b1;
                if (prev_reg == '0)
                begin
                    head_reg <= link_rdata;
                end
            end
            if (state_reg == alle_pkg::S_FINISH && func_reg == alle_pkg::FUNC_INSERT)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == alle_pkg::S_RELINK && prev_reg == '0)
            begin
                head_reg <= fr_reg;
            end
            if (resp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            alle_pkg::S_IDLE:
            begin
                func_reg       <= func;
                data_reg       <= $unsigned(data);
                remain_reg     <= pos - 1'b1;
                cur_reg        <= '0;
                from_head_reg  <= 1'b1;
                res_value_reg  <= '0;
                res_status_reg <= alle_pkg::STAT_OK;
                if (func == alle_pkg::FUNC_INSERT)
                begin
                    if (is_full)
                    begin
                        res_status_reg <= alle_pkg::STAT_FULL;
                    end
                    else if (ins_bad)
                    begin
                        res_status_reg <= alle_pkg::STAT_RANGE;
                    end
                end
                else if (func == alle_pkg::FUNC_DELETE || func == alle_pkg::FUNC_READ)
                begin
                    if (acc_bad)
                    begin
                        res_status_reg <= alle_pkg::STAT_RANGE;
                    end
                end
            end
            alle_pkg::S_WALK:
            begin
                if (walk_done)
                begin
                    prev_reg <= cur_reg;
                    nxt_reg  <= link_now;
                end
                else
                begin
                    // Advance one link; the RAM returns its successor next cycle
                    cur_reg       <= link_now;
                    from_head_reg <= 1'b0;
                    remain_reg    <= remain_reg - 1'b1;
                end
            end
            alle_pkg::S_FINISH:
            begin
                fr_reg <= free_node;
                if (func_reg != alle_pkg::FUNC_INSERT)
                begin
                    res_value_reg <= val_rdata;
                end
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
        if (resp_load)
        begin
            status_reg <= res_status_reg;
            value_reg  <= res_value_reg;
            length_reg <= count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign value     = $signed(value_reg);
    assign length    = length_reg;

endmodule
